// File: hdl/gssm_pkg.sv
// ----------------------------------------------------------------------------
// gssm_pkg: shared types and constants for the gantry squaring stall monitor
// Widths, register indexes, item codes, lane control and merge status structs.
// ----------------------------------------------------------------------------
package gssm_pkg;

	localparam int PORTS      = 4;
	localparam int MAX_MOTORS = 4;
	localparam int POS_W      = 32;
	localparam int STEP_W     = 24;
	localparam int COUNT_W    = 3;
	localparam int WARM_W     = 8;
	localparam int CFG_W      = 24;
	localparam int CFG_IDX_W  = 3;

	// usable motors: smaller of the build limit and the number of ports
	localparam logic [COUNT_W-1:0] MOTOR_LIM =
		COUNT_W'((MAX_MOTORS < PORTS) ? MAX_MOTORS : PORTS);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MOTOR_COUNT    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GANTRY_REVERSE = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_ENCODER_MASK   = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_LIMIT   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_WARMUP_STEPS   = CFG_IDX_W'(5);

	// register reset values
	localparam logic [COUNT_W-1:0] RST_MOTOR_COUNT  = COUNT_W'(1);
	localparam logic [STEP_W-1:0]  RST_TRAVEL_LIMIT = STEP_W'(4096);
	localparam logic [WARM_W-1:0]  RST_WARMUP_STEPS = WARM_W'(10);

	// item function codes
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_STEP  = 1'b1;

	// control shared by all lanes for one item
	typedef struct packed {
		logic accept;
		logic start;
		logic check;
	} gssm_lane_ctl_t;

	// merged run status for the next state
	typedef struct packed {
		logic [PORTS-1:0]   stalled_next;
		logic [COUNT_W-1:0] remaining_next;
		logic               running_next;
		logic               done;
		logic               overrun;
	} gssm_status_t;

	function automatic logic [COUNT_W-1:0] popcount(input logic [PORTS-1:0] m);
		logic [COUNT_W-1:0] c;
		c = '0;
		for (int i = 0; i < PORTS; i++) begin
			c = c + COUNT_W'(m[i]);
		end
		return c;
	endfunction

endpackage

// File: hdl/gssm_lane.sv
// ----------------------------------------------------------------------------
// gssm_lane: per-motor progress check
// Holds the motor's last encoder position and flags a new stall.
// ----------------------------------------------------------------------------
module gssm_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gssm_pkg::gssm_lane_ctl_t      ctl,
	input  logic signed [gssm_pkg::POS_W-1:0] position,
	input  logic                          has_enc,
	input  logic                          dir_rev,
	input  logic                          stalled,
	input  logic                          flag,
	output logic                          newly
);
	import gssm_pkg::*;

	logic signed [POS_W-1:0] last_q;
	logic signed [POS_W-1:0] now;
	logic signed [POS_W-1:0] base;
	logic                    moving;
	logic                    checked;

	// a motor without encoder reads as position zero
	assign now     = has_enc ? position : '0;
	assign base    = ctl.start ? now : last_q;
	assign moving  = !has_enc || (dir_rev ? (now < base) : (now > base));
	assign checked = ctl.check && !stalled;
	assign newly   = checked && (flag || !moving);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (ctl.accept && (ctl.start || checked)) begin
			last_q <= now;
		end
	end

endmodule

// File: hdl/gssm_merge.sv
// ----------------------------------------------------------------------------
// gssm_merge: combine lane results into the run status
// Folds new stalls into the mask, counts motors left, decides done/overrun.
// ----------------------------------------------------------------------------
module gssm_merge (
	input  logic [gssm_pkg::PORTS-1:0]   newly,
	input  logic [gssm_pkg::PORTS-1:0]   stalled,
	input  logic [gssm_pkg::COUNT_W-1:0] remaining,
	input  logic                         start,
	input  logic                         check,
	input  logic                         running,
	input  logic [gssm_pkg::STEP_W-1:0]  step_n,
	input  logic [gssm_pkg::STEP_W-1:0]  travel_limit,
	output gssm_pkg::gssm_status_t       status
);
	import gssm_pkg::*;

	logic [PORTS-1:0]   stalled_next;
	logic [COUNT_W-1:0] remaining_next;
	logic               done;
	logic               over;

	always_comb begin
		stalled_next   = stalled | newly;
		remaining_next = (start || check) ? popcount(~stalled_next) : remaining;
		done           = running && (remaining_next == '0);
		over           = running && !done && (step_n >= travel_limit);

		status.stalled_next   = stalled_next;
		status.remaining_next = remaining_next;
		status.running_next   = running && !done && !over;
		status.done           = done;
		status.overrun        = over;
	end

endmodule

// File: hdl/gantry_squaring_stall_monitor.sv
// ----------------------------------------------------------------------------
// gantry_squaring_stall_monitor: stall-based squaring of a multi-motor gantry
// Each accepted item's result is registered; a skid register takes one more
// item while the output is stalled. Throughput: one item per cycle while
// in_stall is low; four motor lanes check in parallel and a merge stage
// folds their stalls into the run state in the same cycle.
// Reset (arst_n low, asynchronous): registers to defaults, run idle, no result.
// ----------------------------------------------------------------------------
module gantry_squaring_stall_monitor (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [gssm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gssm_pkg::CFG_W-1:0]       cfg_data,
	// item input channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             func,
	input  logic signed [gssm_pkg::POS_W-1:0] position_a,
	input  logic signed [gssm_pkg::POS_W-1:0] position_b,
	input  logic signed [gssm_pkg::POS_W-1:0] position_c,
	input  logic signed [gssm_pkg::POS_W-1:0] position_d,
	input  logic [gssm_pkg::PORTS-1:0]       stall_flags,
	// result channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [gssm_pkg::PORTS-1:0]       step_enable_mask,
	output logic [gssm_pkg::PORTS-1:0]       direction_mask,
	output logic [gssm_pkg::PORTS-1:0]       stall_clear_mask,
	output logic [gssm_pkg::COUNT_W-1:0]     motors_left,
	output logic [gssm_pkg::STEP_W-1:0]      step_number,
	output logic                             done_res,
	output logic                             overrun
);
	import gssm_pkg::*;

	typedef struct packed {
		logic [PORTS-1:0]   step_enable_mask;
		logic [PORTS-1:0]   direction_mask;
		logic [PORTS-1:0]   stall_clear_mask;
		logic [COUNT_W-1:0] motors_left;
		logic [STEP_W-1:0]  step_number;
		logic               done_res;
		logic               overrun;
	} gssm_result_t;

	// configuration registers
	logic [COUNT_W-1:0] motor_count_q;
	logic               gantry_reverse_q;
	logic [PORTS-1:0]   invert_mask_q;
	logic [PORTS-1:0]   encoder_mask_q;
	logic [STEP_W-1:0]  travel_limit_q;
	logic [WARM_W-1:0]  warmup_steps_q;

	// run state
	logic [PORTS-1:0]   stalled_q;
	logic [COUNT_W-1:0] remaining_q;
	logic [STEP_W-1:0]  counter_q;
	logic               running_q;

	// output register and skid stage
	gssm_result_t       out_q;
	logic               out_valid_q;
	gssm_result_t       skid_q;
	logic               skid_valid_q;

	logic               in_acc;
	logic               out_acc;
	logic               start;
	logic               running_eff;
	logic [STEP_W-1:0]  step_n;
	logic [COUNT_W-1:0] used_n;
	logic [PORTS-1:0]   used;
	logic [PORTS-1:0]   stalled_eff;
	logic [PORTS-1:0]   dmask;
	logic               check;
	logic [PORTS-1:0]   newly;
	logic signed [POS_W-1:0] pos [PORTS];
	gssm_lane_ctl_t     lane_ctl;
	gssm_status_t       status;
	gssm_result_t       res;

	// Handshake: take an item unless the skid stage is already holding one.
	assign in_acc   = in_valid && !skid_valid_q;
	assign in_stall = skid_valid_q;
	assign out_acc  = out_valid_q && !out_stall;

	assign start       = (func == FUNC_START);
	assign running_eff = start || running_q;

	// Step index: zero on start, advance (saturating) while running, else hold.
	always_comb begin
		if (start) begin
			step_n = '0;
		end else if (running_q && (counter_q != '1)) begin
			step_n = counter_q + STEP_W'(1);
		end else begin
			step_n = counter_q;
		end
	end

	// Clamp the motor count into 1..limit and expand it to a lane mask.
	always_comb begin
		if (motor_count_q == '0) begin
			used_n = COUNT_W'(1);
		end else if (motor_count_q > MOTOR_LIM) begin
			used_n = MOTOR_LIM;
		end else begin
			used_n = motor_count_q;
		end
		for (int i = 0; i < PORTS; i++) begin
			used[i] = (COUNT_W'(i) < used_n);
		end
	end

	// Direction per motor: gantry direction flipped by the mounting.
	assign dmask = ({PORTS{gantry_reverse_q}} ^ invert_mask_q) & used;

	// A start marks unused motors stalled before the step-0 check.
	assign stalled_eff = start ? ~used : stalled_q;

	// Skip checks during warm-up.
	assign check = running_eff && (step_n >= STEP_W'(warmup_steps_q));

	assign lane_ctl.accept = in_acc;
	assign lane_ctl.start  = start;
	assign lane_ctl.check  = check;

	assign pos[0] = position_a;
	assign pos[1] = position_b;
	assign pos[2] = position_c;
	assign pos[3] = position_d;

	// One lane per motor port.
	for (genvar g = 0; g < PORTS; g++) begin : g_lane
		gssm_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (lane_ctl),
			.position (pos[g]),
			.has_enc  (encoder_mask_q[g]),
			.dir_rev  (dmask[g]),
			.stalled  (stalled_eff[g]),
			.flag     (stall_flags[g]),
			.newly    (newly[g])
		);
	end

	gssm_merge u_merge (
		.newly        (newly),
		.stalled      (stalled_eff),
		.remaining    (remaining_q),
		.start        (start),
		.check        (check),
		.running      (running_eff),
		.step_n       (step_n),
		.travel_limit (travel_limit_q),
		.status       (status)
	);

	// Assemble the result for this item.
	always_comb begin
		res.step_enable_mask = ~status.stalled_next;
		res.direction_mask   = dmask;
		res.stall_clear_mask = newly;
		res.motors_left      = status.remaining_next;
		res.step_number      = step_n;
		res.done_res         = status.done;
		res.overrun          = status.overrun;
	end

	// Configuration writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_count_q    <= RST_MOTOR_COUNT;
			gantry_reverse_q <= 1'b0;
			invert_mask_q    <= '0;
			encoder_mask_q   <= '0;
			travel_limit_q   <= RST_TRAVEL_LIMIT;
			warmup_steps_q   <= RST_WARMUP_STEPS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MOTOR_COUNT:    motor_count_q    <= cfg_data[COUNT_W-1:0];
				REG_GANTRY_REVERSE: gantry_reverse_q <= cfg_data[0];
				REG_INVERT_MASK:    invert_mask_q    <= cfg_data[PORTS-1:0];
				REG_ENCODER_MASK:   encoder_mask_q   <= cfg_data[PORTS-1:0];
				REG_TRAVEL_LIMIT:   travel_limit_q   <= cfg_data[STEP_W-1:0];
				REG_WARMUP_STEPS:   warmup_steps_q   <= cfg_data[WARM_W-1:0];
				default: ;
			endcase
		end
	end

	// Run state advances on every accepted item; an idle step leaves it as is.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stalled_q   <= '0;
			remaining_q <= '0;
			counter_q   <= '0;
			running_q   <= 1'b0;
		end else if (in_acc) begin
			stalled_q   <= status.stalled_next;
			remaining_q <= status.remaining_next;
			counter_q   <= step_n;
			running_q   <= status.running_next;
		end
	end

	// Output register with skid: refill from skid first, else from the new item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_acc) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= in_acc;
			end
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_acc) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_acc) begin
				out_q <= res;
			end
		end else if (in_acc) begin
			skid_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign step_enable_mask = out_q.step_enable_mask;
	assign direction_mask   = out_q.direction_mask;
	assign stall_clear_mask = out_q.stall_clear_mask;
	assign motors_left      = out_q.motors_left;
	assign step_number      = out_q.step_number;
	assign done_res         = out_q.done_res;
	assign overrun          = out_q.overrun;

endmodule

// File: tb/sv/tb_gantry_squaring_stall_monitor.sv
// ----------------------------------------------------------------------------
// tb_gantry_squaring_stall_monitor: self-checking bench for the stall monitor
// Drives start and step items carrying encoder positions and driver stall
// flags. A built-in predictor tracks the squaring run and checks every result
// field. Runs go through several register settings, extremes included, with
// random idling on both channels.
// ----------------------------------------------------------------------------
module tb_gantry_squaring_stall_monitor;
	import gssm_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 1750;

	// one input item: four packed positions, motor 0 in the low word
	typedef struct packed {
		logic                       func;
		logic [PORTS-1:0][POS_W-1:0] pos;
		logic [PORTS-1:0]           flags;
	} motor_item_t;

	// one result item, field for field as the block reports it
	typedef struct packed {
		logic [PORTS-1:0]   enable;
		logic [PORTS-1:0]   heading;
		logic [PORTS-1:0]   cleared;
		logic [COUNT_W-1:0] left;
		logic [STEP_W-1:0]  step;
		logic               done;
		logic               over;
	} squaring_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    func = FUNC_START;
	logic signed [POS_W-1:0] position_a = '0;
	logic signed [POS_W-1:0] position_b = '0;
	logic signed [POS_W-1:0] position_c = '0;
	logic signed [POS_W-1:0] position_d = '0;
	logic [PORTS-1:0]        stall_flags = '0;

	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [PORTS-1:0]   step_enable_mask;
	logic [PORTS-1:0]   direction_mask;
	logic [PORTS-1:0]   stall_clear_mask;
	logic [COUNT_W-1:0] motors_left;
	logic [STEP_W-1:0]  step_number;
	logic               done_res;
	logic               overrun;

	gantry_squaring_stall_monitor uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.func             (func),
		.position_a       (position_a),
		.position_b       (position_b),
		.position_c       (position_c),
		.position_d       (position_d),
		.stall_flags      (stall_flags),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.step_enable_mask (step_enable_mask),
		.direction_mask   (direction_mask),
		.stall_clear_mask (stall_clear_mask),
		.motors_left      (motors_left),
		.step_number      (step_number),
		.done_res         (done_res),
		.overrun          (overrun)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Register shadow: mirrors what the block holds after each write
	// ------------------------------------------------------------------
	logic [COUNT_W-1:0] set_motors  = RST_MOTOR_COUNT;
	logic               set_reverse = 1'b0;
	logic [PORTS-1:0]   set_invert  = '0;
	logic [PORTS-1:0]   set_encoder = '0;
	logic [STEP_W-1:0]  set_axis    = RST_TRAVEL_LIMIT;
	logic [WARM_W-1:0]  set_warmup  = RST_WARMUP_STEPS;

	// Run state of the predictor, all zero after reset
	logic signed [POS_W-1:0] latched_pos [PORTS];
	logic [PORTS-1:0]        stalled_set = '0;
	logic [COUNT_W-1:0]      motors_moving = '0;
	logic [STEP_W-1:0]       step_ctr = '0;
	logic                    run_active = 1'b0;

	initial begin
		for (int i = 0; i < PORTS; i++) begin
			latched_pos[i] = '0;
		end
	end

	motor_item_t      pending_items [$];
	squaring_report_t predicted_reports [$];

	int items_queued = 0;
	int items_taken = 0;
	int results_seen = 0;
	int fault_count = 0;
	int cycle_count = 0;

	// Motors in use: zero counts as one, clamp to what the build supports
	function automatic logic [PORTS-1:0] motors_in_use();
		logic [COUNT_W-1:0] n;
		n = set_motors;
		if (n == 0) begin
			n = 1;
		end
		if (n > MOTOR_LIM) begin
			n = MOTOR_LIM;
		end
		return PORTS'((1 << n) - 1);
	endfunction

	function automatic logic [PORTS-1:0] heading_mask();
		return ({PORTS{set_reverse}} ^ set_invert) & motors_in_use();
	endfunction

	// ------------------------------------------------------------------
	// Predictor: advance the run by one item and report what the block
	// must answer
	// ------------------------------------------------------------------
	function automatic squaring_report_t predict_squaring_step(motor_item_t it);
		squaring_report_t        rep;
		logic [PORTS-1:0]        heading;
		logic [PORTS-1:0]        used;
		logic [PORTS-1:0]        fresh;
		logic [STEP_W-1:0]       n;
		logic signed [POS_W-1:0] now_pos;
		logic                    moving;
		heading = heading_mask();
		used = motors_in_use();
		fresh = '0;
		rep.done = 1'b0;
		rep.over = 1'b0;
		if (it.func == FUNC_START) begin
			// latch positions; unused motors count as already stalled
			for (int i = 0; i < PORTS; i++) begin
				latched_pos[i] = set_encoder[i] ? it.pos[i] : '0;
			end
			stalled_set = ~used;
			motors_moving = COUNT_W'($countones(used));
			step_ctr = '0;
			run_active = 1'b1;
			n = '0;
		end else if (run_active) begin
			n = (step_ctr == '1) ? step_ctr : step_ctr + 1'b1;
			step_ctr = n;
		end else begin
			n = step_ctr;
		end
		if (run_active) begin
			if (n >= set_warmup) begin
				for (int i = 0; i < PORTS; i++) begin
					if (!stalled_set[i]) begin
						now_pos = set_encoder[i] ? it.pos[i] : '0;
						if (!set_encoder[i]) begin
							moving = 1'b1;
						end else if (heading[i]) begin
							moving = now_pos < latched_pos[i];
						end else begin
							moving = now_pos > latched_pos[i];
						end
						latched_pos[i] = now_pos;
						if (it.flags[i] || !moving) begin
							fresh[i] = 1'b1;
						end
					end
				end
				stalled_set = stalled_set | fresh;
				motors_moving = COUNT_W'($countones(~stalled_set));
			end
			if (motors_moving == 0) begin
				rep.done = 1'b1;
				run_active = 1'b0;
			end else if (n >= set_axis) begin
				rep.over = 1'b1;
				run_active = 1'b0;
			end
		end
		rep.enable = ~stalled_set;
		rep.heading = heading;
		rep.cleared = fresh;
		rep.left = motors_moving;
		rep.step = n;
		return rep;
	endfunction

	// ------------------------------------------------------------------
	// Idling: sender light / receiver heavy, then swapped, then none
	// ------------------------------------------------------------------
	function automatic bit sender_gap();
		int pct;
		pct = (items_taken < 600) ? 18 : (items_taken < 1200) ? 56 : 0;
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic bit receiver_gap();
		int pct;
		pct = (items_taken < 600) ? 56 : (items_taken < 1200) ? 18 : 0;
		return $urandom_range(0, 99) < pct;
	endfunction

	// ------------------------------------------------------------------
	// Driver: present the next item once the current one is taken
	// ------------------------------------------------------------------
	motor_item_t cur_item = '0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			// item taken at this edge: predict its result now
			if (in_valid && !in_stall) begin
				predicted_reports.push_back(predict_squaring_step(cur_item));
				items_taken <= items_taken + 1;
			end
			// hold a stalled item; otherwise advance or drop valid
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 && !sender_gap()) begin
					cur_item = pending_items.pop_front();
					in_valid <= 1'b1;
					func <= cur_item.func;
					position_a <= cur_item.pos[0];
					position_b <= cur_item.pos[1];
					position_c <= cur_item.pos[2];
					position_d <= cur_item.pos[3];
					stall_flags <= cur_item.flags;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compare each taken result with the oldest prediction
	// ------------------------------------------------------------------
	squaring_report_t seen_rep;
	squaring_report_t want_rep;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				seen_rep = '{step_enable_mask, direction_mask, stall_clear_mask,
					motors_left, step_number, done_res, overrun};
				if (predicted_reports.size() == 0) begin
					if (fault_count < 10) begin
						$display("unexpected result: en=%h dir=%h clr=%h left=%0d step=%0d",
							seen_rep.enable, seen_rep.heading, seen_rep.cleared,
							seen_rep.left, seen_rep.step);
					end
					fault_count++;
				end else begin
					want_rep = predicted_reports.pop_front();
					results_seen++;
					if (seen_rep.enable !== want_rep.enable
						|| seen_rep.heading !== want_rep.heading
						|| seen_rep.cleared !== want_rep.cleared
						|| seen_rep.left !== want_rep.left
						|| seen_rep.step !== want_rep.step
						|| seen_rep.done !== want_rep.done
						|| seen_rep.over !== want_rep.over) begin
						if (fault_count < 10) begin
							$display("result %0d: expected en=%h dir=%h clr=%h left=%0d step=%0d done=%b over=%b",
								results_seen, want_rep.enable, want_rep.heading,
								want_rep.cleared, want_rep.left, want_rep.step,
								want_rep.done, want_rep.over);
							$display("result %0d: actual   en=%h dir=%h clr=%h left=%0d step=%0d done=%b over=%b",
								results_seen, seen_rep.enable, seen_rep.heading,
								seen_rep.cleared, seen_rep.left, seen_rep.step,
								seen_rep.done, seen_rep.over);
						end
						fault_count++;
					end
				end
			end
			out_stall <= receiver_gap();
		end
	end

	// Watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_gantry_squaring_stall_monitor NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic add_item(input logic f, input logic [POS_W-1:0] a,
		input logic [POS_W-1:0] b, input logic [POS_W-1:0] c,
		input logic [POS_W-1:0] d, input logic [PORTS-1:0] fl);
		motor_item_t it;
		it.func = f;
		it.pos = {d, c, b, a};
		it.flags = fl;
		pending_items.push_back(it);
		items_queued++;
	endtask

	// Write one register and update the shadow; valid keeps low meanwhile
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			REG_MOTOR_COUNT:    set_motors  = v[COUNT_W-1:0];
			REG_GANTRY_REVERSE: set_reverse = v[0];
			REG_INVERT_MASK:    set_invert  = v[PORTS-1:0];
			REG_ENCODER_MASK:   set_encoder = v[PORTS-1:0];
			REG_TRAVEL_LIMIT:   set_axis    = v[STEP_W-1:0];
			REG_WARMUP_STEPS:   set_warmup  = v[WARM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(input int motors, input int rev, input int inv,
		input int enc, input int axis, input int warm);
		write_reg(REG_MOTOR_COUNT, CFG_W'(motors));
		write_reg(REG_GANTRY_REVERSE, CFG_W'(rev));
		write_reg(REG_INVERT_MASK, CFG_W'(inv));
		write_reg(REG_ENCODER_MASK, CFG_W'(enc));
		write_reg(REG_TRAVEL_LIMIT, CFG_W'(axis));
		write_reg(REG_WARMUP_STEPS, CFG_W'(warm));
		end_writes();
	endtask

	// Every item answers once, so idle means all queued results are back
	task automatic drain();
		while (results_seen != items_queued) begin
			@(posedge clk);
		end
		repeat (3) @(posedge clk);
	endtask

	function automatic bit motor_reverse(int i);
		return set_reverse ^ set_invert[i];
	endfunction

	// One run: start, then steps that mostly advance each motor in its own
	// direction; a broken run carries random positions instead
	task automatic gen_run(input bit broken);
		logic [PORTS-1:0][POS_W-1:0] p;
		logic [PORTS-1:0]            fl;
		logic [POS_W-1:0]            delta;
		int                          steps;
		for (int i = 0; i < PORTS; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				// start next to the signed limit so advancing wraps around
				p[i] = motor_reverse(i) ? 32'h8000_0000 + $urandom_range(0, 40)
					: 32'h7FFF_FFFF - $urandom_range(0, 40);
			end else begin
				p[i] = $urandom;
			end
		end
		fl = ($urandom_range(0, 7) == 0) ? PORTS'($urandom) : '0;
		add_item(FUNC_START, p[0], p[1], p[2], p[3], fl);
		steps = set_warmup + $urandom_range(1, 30);
		for (int s = 0; s < steps; s++) begin
			for (int i = 0; i < PORTS; i++) begin
				if (broken) begin
					p[i] = $urandom;
				end else begin
					if ($urandom_range(0, 99) < 5) begin
						delta = 32'd0 - 32'($urandom_range(0, 3));
					end else begin
						delta = 32'($urandom_range(1, 200));
					end
					p[i] = motor_reverse(i) ? p[i] - delta : p[i] + delta;
				end
				fl[i] = $urandom_range(0, 99) < 3;
			end
			add_item(FUNC_STEP, p[0], p[1], p[2], p[3], fl);
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence: reset, directed cases, then random phases
	// ------------------------------------------------------------------
	initial begin
		int phase;
		int phase_end;
		int roll;
		int axis;
		int warm;
		int motors;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// defaults: step before any start, then a run with extreme positions
		add_item(FUNC_STEP, 32'd5, 32'd6, 32'd7, 32'd8, 4'hF);
		add_item(FUNC_START, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 4'hF);
		add_item(FUNC_STEP, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0);
		drain();

		// lower the axis length mid-run: next step overruns, then idle step
		write_reg(REG_TRAVEL_LIMIT, CFG_W'(1));
		end_writes();
		add_item(FUNC_STEP, 32'h1, 32'h2, 32'h3, 32'h4, 4'h0);
		add_item(FUNC_STEP, 32'h1, 32'h2, 32'h3, 32'h4, 4'h0);
		drain();

		// no warm-up: every encoded motor stalls at the start itself
		write_all(4, 1, 4'b0101, 4'hF, 100, 0);
		add_item(FUNC_START, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 4'h0);
		add_item(FUNC_STEP, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0);
		drain();

		// axis length zero: start overruns unless all motors flag a stall
		write_all(7, 0, 4'h0, 4'h0, 0, 0);
		add_item(FUNC_START, 32'h10, 32'h20, 32'h30, 32'h40, 4'h0);
		add_item(FUNC_START, 32'h10, 32'h20, 32'h30, 32'h40, 4'hF);
		drain();

		// motor count zero means one motor; signed wrap is a stall
		write_all(0, 0, 4'h0, 4'hF, 3, 1);
		add_item(FUNC_START, 32'h7FFF_FFFE, 32'h0, 32'h0, 32'h0, 4'h0);
		add_item(FUNC_STEP, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 4'h0);
		add_item(FUNC_STEP, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 4'h0);
		drain();

		// mixed directions, one motor without encoder, flag and no-progress stalls
		write_all(5, 1, 4'b1010, 4'b0111, 4, 1);
		add_item(FUNC_START, 32'd10, 32'd10, 32'd10, 32'd10, 4'h0);
		add_item(FUNC_STEP, 32'd9, 32'd11, 32'd9, 32'd5, 4'h0);
		add_item(FUNC_STEP, 32'd9, 32'd12, 32'd8, 32'd5, 4'b1000);
		add_item(FUNC_STEP, 32'd9, 32'd12, 32'd7, 32'd5, 4'h0);
		add_item(FUNC_STEP, 32'd9, 32'd12, 32'd8, 32'd5, 4'h0);
		drain();

		// random phases; the first two pin the register extremes
		phase = 0;
		phase_end = items_queued;
		while (items_queued < phase_end + RANDOM_ITEMS - (phase_end - items_queued)
			&& items_queued < 17 + RANDOM_ITEMS) begin
			motors = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) * $urandom_range(0, 1)
				: $urandom_range(1, 4);
			axis = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(4, 60);
			warm = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 12);
			if (phase == 0) begin
				axis = 24'hFF_FFFF;
				warm = 255;
			end else if (phase == 1) begin
				axis = 1;
				warm = 0;
			end
			write_all(motors, $urandom_range(0, 1), $urandom_range(0, 15),
				$urandom_range(0, 15) | (($urandom_range(0, 1) == 0) ? 15 : 0), axis, warm);
			phase_end = items_queued + ((phase == 0) ? 320 : 130);
			while (items_queued < phase_end) begin
				roll = $urandom_range(0, 9);
				if (roll < 8) begin
					gen_run(1'b0);
				end else if (roll == 8) begin
					gen_run(1'b1);
				end else begin
					// noise: a short burst of arbitrary items
					repeat ($urandom_range(1, 4)) begin
						add_item(logic'($urandom_range(0, 1)), $urandom, $urandom,
							$urandom, $urandom, PORTS'($urandom));
					end
				end
			end
			drain();
			phase++;
		end

		repeat (5) @(posedge clk);
		if (fault_count == 0) begin
			$display("tb_gantry_squaring_stall_monitor OK");
		end else begin
			$display("tb_gantry_squaring_stall_monitor NOT OK");
		end
		$finish;
	end

endmodule
